@@ hdl/expiring_batch_edf_server_assert.svh @@
// assertion macros for the expiring batch edf server
// no dependencies; included by the server module, which checks its own logic
`ifndef EXPIRING_BATCH_EDF_SERVER_ASSERT_SVH
`define EXPIRING_BATCH_EDF_SERVER_ASSERT_SVH

`ifndef SYNTHESIS

// check a property on every rising clock edge outside reset
`define EDF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// check a property on every rising clock edge, reset included
`define EDF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define EDF_ASSERT(lbl, clk, rst_n, prop)
`define EDF_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hdl/edf_srv_pkg.sv @@
// types, constants and helpers for the expiring batch edf server
// no dependencies
package edf_srv_pkg;

  localparam int unsigned EXP_W = 32;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned QTY_W = 16;
  localparam int unsigned LIFE_W = 16;

  // one heap entry: expiry tick and units left
  typedef struct packed {
    logic [EXP_W-1:0] expiry;
    logic [CNT_W-1:0] count;
  } batch_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_UP_ROOT,
    ST_SERVE,
    ST_DROP,
    ST_POP_LAST,
    ST_DN_CMP,
    ST_DN_FIN
  } state_e;

  // serial order on wrapping ticks: a strictly before b
  function automatic logic before_f(input logic [EXP_W-1:0] a, input logic [EXP_W-1:0] b);
    logic [EXP_W-1:0] diff;
    diff = a - b;
    return diff[EXP_W-1];
  endfunction

endpackage

@@ hdl/expiring_batch_edf_server.sv @@
// expiring batch server: earliest-deadline-first min-heap in one two-read memory
// sequence: accept, then on insert into a filled heap sift up (ST_UP_CMP per level, ST_UP_ROOT),
// serve in ST_SERVE, sift down (ST_POP_LAST, ST_DN_CMP, ST_DN_FIN) when the served batch runs out
// and per dead batch dropped in ST_DROP; start is taken again only in idle, from the cycle of done_o
// reset: async active low clears occupancy, tick and served count; heap memory is not cleared
// depends on edf_srv_pkg and expiring_batch_edf_server_assert.svh
`include "expiring_batch_edf_server_assert.svh"

module expiring_batch_edf_server #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [edf_srv_pkg::QTY_W-1:0]    quantity_i,
  input  logic [edf_srv_pkg::LIFE_W-1:0]   shelf_life_i,
  output logic                             done_o,
  output logic                             served_o,
  output logic [31:0]                      total_served_o,
  output logic                             store_empty_o,
  output logic                             overflow_o
);

  import edf_srv_pkg::*;

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned KW = AW + 1;

  // control and payload registers
  state_e           state_q, state_d;
  logic [CW-1:0]    occ_q, occ_d;
  logic [AW-1:0]    idx_q, idx_d;
  batch_t           item_q, item_d;
  batch_t           top_q;
  logic [EXP_W-1:0] tick_q, tick_d;
  logic [31:0]      total_q, total_d;
  logic             srv_q, srv_d;
  logic             ovf_q, ovf_d;
  logic             done_q, done_d;
  logic             served_q, served_d;
  logic [31:0]      total_out_q, total_out_d;
  logic             empty_q, empty_d;
  logic             ovfo_q, ovfo_d;

  // memory ports
  batch_t           mem_q [STORE_DEPTH];
  logic             we_c;
  logic [AW-1:0]    wa_c;
  batch_t           wd_c;
  logic [AW-1:0]    ra_a_c, ra_b_c;
  batch_t           rd_a_q, rd_b_q;

  // helpers for the sequencer
  logic             accept_c;
  logic             has_batch_c;
  logic [AW-1:0]    occ_ix_c;
  logic [CW-1:0]    occ_m1_c;
  logic [AW-1:0]    par_occ_c, par_idx_c, par_par_c;
  logic [KW-1:0]    occ_k_c, l_k_c, r_k_c, ml_k_c, mr_k_c;
  logic             lv_c, rv_c, moved_c;
  logic [AW-1:0]    m_ix_c;
  batch_t           best_c;
  batch_t           new_batch_c;

  assign busy     = (state_q != ST_IDLE);
  assign accept_c = start && !busy;
  assign has_batch_c = (quantity_i != '0) && (shelf_life_i != '0);

  // index arithmetic
  assign occ_ix_c  = occ_q[AW-1:0];
  assign occ_m1_c  = occ_q - CW'(1);
  assign par_occ_c = AW'(occ_ix_c - AW'(1)) >> 1;
  assign par_idx_c = AW'(idx_q - AW'(1)) >> 1;
  assign par_par_c = AW'(par_idx_c - AW'(1)) >> 1;
  assign occ_k_c   = KW'(occ_q);
  assign l_k_c     = {idx_q, 1'b1};
  assign r_k_c     = {idx_q, 1'b0} + KW'(2);
  assign lv_c      = (l_k_c < occ_k_c);
  assign rv_c      = (r_k_c < occ_k_c);
  assign ml_k_c    = {m_ix_c, 1'b1};
  assign mr_k_c    = ml_k_c + KW'(1);

  // new batch built from the transaction
  assign new_batch_c.expiry = tick_q + EXP_W'(shelf_life_i) - EXP_W'(1);
  assign new_batch_c.count  = CNT_W'(quantity_i);

  // pick the earliest of the hole item and its live children
  always_comb begin
    best_c  = item_q;
    m_ix_c  = idx_q;
    moved_c = 1'b0;
    if (lv_c && before_f(rd_a_q.expiry, best_c.expiry)) begin
      best_c  = rd_a_q;
      m_ix_c  = l_k_c[AW-1:0];
      moved_c = 1'b1;
    end
    if (rv_c && before_f(rd_b_q.expiry, best_c.expiry)) begin
      best_c  = rd_b_q;
      m_ix_c  = r_k_c[AW-1:0];
      moved_c = 1'b1;
    end
  end

  // state register and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
      tick_q  <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      tick_q  <= tick_d;
      total_q <= total_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    item_q      <= item_d;
    srv_q       <= srv_d;
    ovf_q       <= ovf_d;
    served_q    <= served_d;
    total_out_q <= total_out_d;
    empty_q     <= empty_d;
    ovfo_q      <= ovfo_d;
  end

  // heap memory, one write and two registered reads, plus a shadow of the root
  always_ff @(posedge clk_i) begin
    if (we_c) begin
      mem_q[wa_c] <= wd_c;
    end
    if (we_c && (wa_c == '0)) begin
      top_q <= wd_c;
    end
    rd_a_q <= mem_q[ra_a_c];
    rd_b_q <= mem_q[ra_b_c];
  end

  // sequencer: insert with sift up, serve the root, remove emptied and dead roots with sift down
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    item_d      = item_q;
    tick_d      = tick_q;
    total_d     = total_q;
    srv_d       = srv_q;
    ovf_d       = ovf_q;
    done_d      = 1'b0;
    served_d    = served_q;
    total_out_d = total_out_q;
    empty_d     = empty_q;
    ovfo_d      = ovfo_q;
    we_c        = 1'b0;
    wa_c        = idx_q;
    wd_c        = item_q;
    ra_a_c      = '0;
    ra_b_c      = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept_c) begin
          srv_d   = 1'b0;
          ovf_d   = 1'b0;
          state_d = ST_SERVE;
          if (has_batch_c) begin
            if (occ_q == CW'(STORE_DEPTH)) begin
              ovf_d = 1'b1;
            end else begin
              occ_d = occ_q + CW'(1);
              if (occ_q == '0) begin
                we_c = 1'b1;
                wa_c = '0;
                wd_c = new_batch_c;
              end else begin
                ra_a_c  = par_occ_c;
                idx_d   = occ_ix_c;
                item_d  = new_batch_c;
                state_d = ST_UP_CMP;
              end
            end
          end
        end
      end

      // hole at idx_q, parent entry in rd_a_q
      ST_UP_CMP: begin
        we_c = 1'b1;
        wa_c = idx_q;
        if (before_f(item_q.expiry, rd_a_q.expiry)) begin
          wd_c  = rd_a_q;
          idx_d = par_idx_c;
          if (par_idx_c == '0) begin
            state_d = ST_UP_ROOT;
          end else begin
            ra_a_c = par_par_c;
          end
        end else begin
          wd_c    = item_q;
          state_d = ST_SERVE;
        end
      end

      ST_UP_ROOT: begin
        we_c    = 1'b1;
        wa_c    = idx_q;
        wd_c    = item_q;
        state_d = ST_SERVE;
      end

      // serve one unit from the root; stored roots are always live here
      ST_SERVE: begin
        state_d = ST_DROP;
        if (occ_q != '0) begin
          srv_d   = 1'b1;
          total_d = total_q + 32'd1;
          if (top_q.count != CNT_W'(1)) begin
            we_c        = 1'b1;
            wa_c        = '0;
            wd_c.expiry = top_q.expiry;
            wd_c.count  = top_q.count - CNT_W'(1);
          end else begin
            occ_d = occ_m1_c;
            if (occ_q != CW'(1)) begin
              ra_a_c  = occ_m1_c[AW-1:0];
              state_d = ST_POP_LAST;
            end
          end
        end
      end

      // remove roots that are not live next tick, else close the transaction
      ST_DROP: begin
        if ((occ_q != '0) && !before_f(tick_q, top_q.expiry)) begin
          occ_d = occ_m1_c;
          if (occ_q != CW'(1)) begin
            ra_a_c  = occ_m1_c[AW-1:0];
            state_d = ST_POP_LAST;
          end
        end else begin
          done_d      = 1'b1;
          served_d    = srv_q;
          total_out_d = total_q;
          empty_d     = (occ_q == '0);
          ovfo_d      = ovf_q;
          tick_d      = tick_q + EXP_W'(1);
          state_d     = ST_IDLE;
        end
      end

      // last entry in rd_a_q moves into the hole at the root
      ST_POP_LAST: begin
        if (occ_q == CW'(1)) begin
          we_c    = 1'b1;
          wa_c    = '0;
          wd_c    = rd_a_q;
          state_d = ST_DROP;
        end else begin
          item_d  = rd_a_q;
          idx_d   = '0;
          ra_a_c  = AW'(1);
          ra_b_c  = (occ_q > CW'(2)) ? AW'(2) : AW'(1);
          state_d = ST_DN_CMP;
        end
      end

      // hole at idx_q, children in rd_a_q and rd_b_q
      ST_DN_CMP: begin
        we_c = 1'b1;
        wa_c = idx_q;
        if (moved_c) begin
          wd_c  = best_c;
          idx_d = m_ix_c;
          if (ml_k_c < occ_k_c) begin
            ra_a_c = ml_k_c[AW-1:0];
            ra_b_c = (mr_k_c < occ_k_c) ? mr_k_c[AW-1:0] : ml_k_c[AW-1:0];
          end else begin
            state_d = ST_DN_FIN;
          end
        end else begin
          wd_c    = item_q;
          state_d = ST_DROP;
        end
      end

      ST_DN_FIN: begin
        we_c    = 1'b1;
        wa_c    = idx_q;
        wd_c    = item_q;
        state_d = ST_DROP;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result ports
  assign done_o         = done_q;
  assign served_o       = served_q;
  assign total_served_o = total_out_q;
  assign store_empty_o  = empty_q;
  assign overflow_o     = ovfo_q;

  // checks on the sequencer
  `EDF_ASSERT_ALWAYS(a_occ_bound, clk_i, occ_q <= CW'(STORE_DEPTH))
  `EDF_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o)
  `EDF_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `EDF_ASSERT(a_hole_in_heap, clk_i, rst_ni, (state_q == ST_DN_CMP) |-> (KW'(idx_q) < occ_k_c))
  `EDF_ASSERT(a_root_nonzero, clk_i, rst_ni, (state_q == ST_SERVE && occ_q != '0) |-> top_q.count != '0)

endmodule
